@@ hw/rtl/s2x_pkg.sv @@
package s2x_pkg;

   localparam int WIDE_PIXELS = 512;
   localparam int NARROW_PIXELS = 256;
   localparam int PIX_W = 16;
   localparam int COL_W = $clog2(WIDE_PIXELS);
   localparam int SLOTS = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QLEVEL_W = $clog2(QUEUE_DEPTH + 1);

   typedef logic [1:0] slot_type;
   typedef logic [PIX_W-1:0] pixel_type;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_DRAIN = 1'b1
   } op_type;

   typedef struct packed {
      logic               en;
      slot_type           slot;
      logic [COL_W-1:0]   addr;
      pixel_type          data;
   } store_write_type;

   typedef struct packed {
      logic     valid;
      slot_type mid;
      slot_type above;
      slot_type below;
      logic     use_a;
      logic     use_e;
      logic     has_d;
      logic     first;
      logic     wide;
      logic     eol;
      logic     eof;
   } issue_type;

   typedef struct packed {
      pixel_type c;
      pixel_type d;
      pixel_type a;
      pixel_type e;
      logic      first;
      logic      wide;
      logic      eol;
      logic      eof;
   } entry_type;

endpackage

@@ hw/rtl/s2x_ifs.sv @@
interface s2x_req_if;
   logic                  valid;
   logic                  ready;
   logic                  opcode;
   logic [15:0]           pixel;
   logic                  wide_line;
   logic                  last_in_line;
   logic                  last_in_frame;

   modport source (output valid, opcode, pixel, wide_line, last_in_line, last_in_frame,
                   input ready);
   modport sink (input valid, opcode, pixel, wide_line, last_in_line, last_in_frame,
                 output ready);
endinterface

interface s2x_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] top_left;
   logic [15:0] top_right;
   logic [15:0] bottom_left;
   logic [15:0] bottom_right;
   logic        wide;
   logic        end_of_line;
   logic        end_of_frame;

   modport source (output valid, top_left, top_right, bottom_left, bottom_right, wide,
                   end_of_line, end_of_frame, input ready);
   modport sink (input valid, top_left, top_right, bottom_left, bottom_right, wide,
                 end_of_line, end_of_frame, output ready);
endinterface

@@ hw/rtl/s2x_ram.sv @@
module s2x_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr_a,
   input  logic [$clog2(DEPTH)-1:0] raddr_b,
   output logic [WIDTH-1:0]         rdata_a,
   output logic [WIDTH-1:0]         rdata_b
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
   end
endmodule

@@ hw/rtl/s2x_front.sv @@
module s2x_front (
   input  logic                          clock,
   input  logic                          reset,
   s2x_req_if.sink                       req,
   input  logic [s2x_pkg::QLEVEL_W-1:0]  q_level,
   output s2x_pkg::store_write_type      store_wr,
   output logic [s2x_pkg::COL_W-1:0]     rd_addr_a,
   output logic [s2x_pkg::COL_W-1:0]     rd_addr_b,
   output s2x_pkg::issue_type            issue
);
   localparam logic [s2x_pkg::COL_W:0] WIDE_CAP = (s2x_pkg::COL_W+1)'(s2x_pkg::WIDE_PIXELS);
   localparam logic [s2x_pkg::COL_W:0] NARROW_CAP =
      (s2x_pkg::COL_W+1)'(s2x_pkg::NARROW_PIXELS);

   logic [s2x_pkg::COL_W-1:0] wr_col_ff, wr_col_in, dr_col_ff, dr_col_in;
   s2x_pkg::slot_type         wr_slot_ff, wr_slot_in;
   logic [1:0]                lines_ff, lines_in;
   logic                      frame_end_ff, frame_end_in;
   logic                      above_ok_ff, above_ok_in;
   logic [2:0]                wide_ff, wide_in;
   s2x_pkg::issue_type        issue_ff, issue_in;

   logic                      fire, do_write, do_drain, close, dr_wide;
   logic [s2x_pkg::COL_W:0]   wr_next, dr_next, cap, cols;
   s2x_pkg::slot_type         mid, above, below;
   logic [1:0]                lines_dec;

   assign req.ready = ({1'b0, q_level} + {{s2x_pkg::QLEVEL_W{1'b0}}, issue_ff.valid})
                      < (s2x_pkg::QLEVEL_W+1)'(s2x_pkg::QUEUE_DEPTH);
   assign fire = req.valid && req.ready;

   always_comb begin
      do_write = fire && (s2x_pkg::op_type'(req.opcode) == s2x_pkg::OP_WRITE)
                 && (lines_ff < 2'd2) && !frame_end_ff;
      do_drain = fire && (s2x_pkg::op_type'(req.opcode) == s2x_pkg::OP_DRAIN)
                 && ((lines_ff == 2'd2) || ((lines_ff == 2'd1) && frame_end_ff));
      cap = req.wide_line ? WIDE_CAP : NARROW_CAP;
      wr_next = {1'b0, wr_col_ff} + 1'b1;
      close = req.last_in_line || req.last_in_frame || (wr_next >= cap);

      if (lines_ff == 2'd1) begin
         mid = (wr_slot_ff == 2'd0) ? 2'd2 : wr_slot_ff - 2'd1;
      end else begin
         mid = (wr_slot_ff >= 2'd2) ? wr_slot_ff - 2'd2 : wr_slot_ff + 2'd1;
      end
      above = (mid == 2'd0) ? 2'd2 : mid - 2'd1;
      below = (mid == 2'd2) ? 2'd0 : mid + 2'd1;
      dr_wide = wide_ff[mid];
      cols = dr_wide ? WIDE_CAP : NARROW_CAP;
      dr_next = {1'b0, dr_col_ff} + 1'b1;
      lines_dec = lines_ff - 2'd1;
   end

   always_comb begin
      wr_col_in = wr_col_ff;
      dr_col_in = dr_col_ff;
      wr_slot_in = wr_slot_ff;
      lines_in = lines_ff;
      frame_end_in = frame_end_ff;
      above_ok_in = above_ok_ff;
      wide_in = wide_ff;
      issue_in = '0;

      if (do_write) begin
         if (close) begin
            wide_in[wr_slot_ff] = req.wide_line;
            wr_slot_in = (wr_slot_ff == 2'd2) ? 2'd0 : wr_slot_ff + 2'd1;
            wr_col_in = '0;
            lines_in = lines_ff + 2'd1;
            if (req.last_in_frame) begin
               frame_end_in = 1'b1;
            end
         end else begin
            wr_col_in = wr_next[s2x_pkg::COL_W-1:0];
         end
      end

      if (do_drain) begin
         issue_in.valid = 1'b1;
         issue_in.mid = mid;
         issue_in.above = above;
         issue_in.below = below;
         issue_in.use_a = above_ok_ff && !wide_ff[above];
         issue_in.use_e = (lines_ff == 2'd2) && !wide_ff[below];
         issue_in.has_d = dr_next < cols;
         issue_in.first = (dr_col_ff == '0);
         issue_in.wide = dr_wide;
         issue_in.eol = dr_next >= cols;
         issue_in.eof = (dr_next >= cols) && frame_end_ff && (lines_dec == 2'd0);
         if (dr_next >= cols) begin
            dr_col_in = '0;
            lines_in = lines_dec;
            if (frame_end_ff && (lines_dec == 2'd0)) begin
               frame_end_in = 1'b0;
               above_ok_in = 1'b0;
            end else begin
               above_ok_in = 1'b1;
            end
         end else begin
            dr_col_in = dr_next[s2x_pkg::COL_W-1:0];
         end
      end
   end

   always_comb begin
      store_wr.en = do_write;
      store_wr.slot = wr_slot_ff;
      store_wr.addr = wr_col_ff;
      store_wr.data = req.pixel;
      rd_addr_a = dr_col_ff;
      rd_addr_b = dr_next[s2x_pkg::COL_W-1:0];
      issue = issue_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_col_ff <= '0;
         dr_col_ff <= '0;
         wr_slot_ff <= '0;
         lines_ff <= '0;
         frame_end_ff <= 1'b0;
         above_ok_ff <= 1'b0;
         wide_ff <= '0;
         issue_ff <= '0;
      end else begin
         wr_col_ff <= wr_col_in;
         dr_col_ff <= dr_col_in;
         wr_slot_ff <= wr_slot_in;
         lines_ff <= lines_in;
         frame_end_ff <= frame_end_in;
         above_ok_ff <= above_ok_in;
         wide_ff <= wide_in;
         issue_ff <= issue_in;
      end
   end
endmodule

@@ hw/rtl/s2x_back.sv @@
module s2x_back (
   input  logic                                         clock,
   input  logic                                         reset,
   input  s2x_pkg::issue_type                           issue,
   input  logic [s2x_pkg::SLOTS-1:0][s2x_pkg::PIX_W-1:0] rd_a,
   input  logic [s2x_pkg::SLOTS-1:0][s2x_pkg::PIX_W-1:0] rd_b,
   output logic [s2x_pkg::QLEVEL_W-1:0]                 q_level,
   s2x_rsp_if.source                                    rsp
);
   s2x_pkg::entry_type                q_ff [s2x_pkg::QUEUE_DEPTH];
   s2x_pkg::entry_type                push_e, head;
   logic [s2x_pkg::QPTR_W-1:0]        wp_ff, wp_in, rp_ff, rp_in;
   logic [s2x_pkg::QLEVEL_W-1:0]      cnt_ff, cnt_in;
   s2x_pkg::pixel_type                prev_c_ff, prev_c_in;
   s2x_pkg::pixel_type                b, tl, tr, bl, br;
   logic                              pop, out_valid_ff, out_valid_in;
   s2x_pkg::pixel_type                tl_ff, tr_ff, bl_ff, br_ff;
   logic                              wide_ff, eol_ff, eof_ff;

   always_comb begin
      push_e.c = rd_a[issue.mid];
      push_e.d = issue.has_d ? rd_b[issue.mid] : rd_a[issue.mid];
      push_e.a = issue.use_a ? rd_a[issue.above] : rd_a[issue.mid];
      push_e.e = issue.use_e ? rd_a[issue.below] : rd_a[issue.mid];
      push_e.first = issue.first;
      push_e.wide = issue.wide;
      push_e.eol = issue.eol;
      push_e.eof = issue.eof;
   end

   always_comb begin
      head = q_ff[rp_ff];
      pop = (cnt_ff != '0) && (!out_valid_ff || rsp.ready);
      b = head.first ? head.c : prev_c_ff;
      tl = head.c;
      tr = head.c;
      bl = head.c;
      br = head.c;
      if (head.wide) begin
         tr = '0;
         br = '0;
      end else if ((head.a != head.e) && (b != head.d)) begin
         if (head.a == b) tl = head.a;
         if (head.a == head.d) tr = head.a;
         if (head.e == b) bl = head.e;
         if (head.e == head.d) br = head.e;
      end
      wp_in = issue.valid ? wp_ff + 1'b1 : wp_ff;
      rp_in = pop ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + {{(s2x_pkg::QLEVEL_W-1){1'b0}}, issue.valid}
               - {{(s2x_pkg::QLEVEL_W-1){1'b0}}, pop};
      prev_c_in = pop ? head.c : prev_c_ff;
      out_valid_in = pop || (out_valid_ff && !rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (issue.valid) begin
         q_ff[wp_ff] <= push_e;
      end
      prev_c_ff <= prev_c_in;
      if (pop) begin
         tl_ff <= tl;
         tr_ff <= tr;
         bl_ff <= bl;
         br_ff <= br;
         wide_ff <= head.wide;
         eol_ff <= head.eol;
         eof_ff <= head.eof;
      end
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign q_level = cnt_ff;
   assign rsp.valid = out_valid_ff;
   assign rsp.top_left = tl_ff;
   assign rsp.top_right = tr_ff;
   assign rsp.bottom_left = bl_ff;
   assign rsp.bottom_right = br_ff;
   assign rsp.wide = wide_ff;
   assign rsp.end_of_line = eol_ff;
   assign rsp.end_of_frame = eof_ff;
endmodule

@@ hw/rtl/scale2x_line_upscaler_unit.sv @@
// Scale2x line upscaler with three rotating line stores.
// The req channel carries words that either write one source pixel into the
// line being filled or drain one output column of the pending line. The rsp
// channel returns one 2x2 block per successful drain word; a wide line gives
// a vertically doubled pixel with zero right-hand outputs.
// A drain word passes through the line store read, the queue and the output
// register before its result appears on rsp. Writes and drains that have no
// effect give no word.
// Throughput is one word per cycle while req_ready is high; each drain reads
// all three line stores on two ports, so every word can enter back to back.
// A four-entry queue between the issue logic and the output register absorbs
// receiver stalls; req_ready falls once the queue and the read in flight
// would fill it, and rises again as rsp takes words.
// Synchronous reset empties all line bookkeeping and the queue; the line
// store contents are left as they are and are read only after being written.
module scale2x_line_upscaler_unit (
   input  logic    clock,
   input  logic    reset,
   s2x_req_if.sink req_if,
   s2x_rsp_if.source rsp_if
);
   s2x_pkg::store_write_type                        store_wr;
   logic [s2x_pkg::COL_W-1:0]                       rd_addr_a, rd_addr_b;
   s2x_pkg::issue_type                              issue;
   logic [s2x_pkg::QLEVEL_W-1:0]                    q_level;
   logic [s2x_pkg::SLOTS-1:0][s2x_pkg::PIX_W-1:0]   rd_a, rd_b;

   s2x_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .q_level   (q_level),
      .store_wr  (store_wr),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .issue     (issue)
   );

   for (genvar s = 0; s < s2x_pkg::SLOTS; s++) begin : g_store
      s2x_ram #(
         .WIDTH (s2x_pkg::PIX_W),
         .DEPTH (s2x_pkg::WIDE_PIXELS)
      ) u_ram (
         .clock   (clock),
         .we      (store_wr.en && (store_wr.slot == 2'(s))),
         .waddr   (store_wr.addr),
         .wdata   (store_wr.data),
         .raddr_a (rd_addr_a),
         .raddr_b (rd_addr_b),
         .rdata_a (rd_a[s]),
         .rdata_b (rd_b[s])
      );
   end

   s2x_back u_back (
      .clock   (clock),
      .reset   (reset),
      .issue   (issue),
      .rd_a    (rd_a),
      .rd_b    (rd_b),
      .q_level (q_level),
      .rsp     (rsp_if)
   );

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_level <= s2x_pkg::QLEVEL_W'(s2x_pkg::QUEUE_DEPTH))
      else $error("queue overflow");

   a_eof_eol: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.end_of_frame |-> rsp_if.end_of_line)
      else $error("end of frame without end of line");

   a_wide_right: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.wide |-> (rsp_if.top_right == '0) && (rsp_if.bottom_right == '0)
      && (rsp_if.top_left == rsp_if.bottom_left))
      else $error("wide column malformed");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      issue.valid |-> q_level < s2x_pkg::QLEVEL_W'(s2x_pkg::QUEUE_DEPTH))
      else $error("issue into full queue");
endmodule
